@@ rtl/ipv6_header_parse_check_defines.svh @@
// Assertion macros shared by the parser RTL.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef IPV6_HEADER_PARSE_CHECK_DEFINES_SVH
`define IPV6_HEADER_PARSE_CHECK_DEFINES_SVH

// Same-cycle implication.
`define IHP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define IHP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/ihp_pkg.sv @@
package ihp_pkg;

  localparam int unsigned HDR_WORDS = 5;

  localparam logic [16:0] HDR_LEN      = 17'd40;
  localparam logic [5:0]  HDR_POS_END  = 6'd40;
  localparam logic [5:0]  POS_VERSION  = 6'd0;
  localparam logic [5:0]  POS_PLEN_LO  = 6'd5;
  localparam logic [5:0]  POS_HOP      = 6'd7;
  localparam logic [5:0]  POS_LAST     = 6'd39;
  localparam logic [3:0]  IP_VERSION   = 4'h6;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_SHORT   = 3'd1,
    ST_VERSION = 3'd2,
    ST_TRUNC   = 3'd3,
    ST_HOP     = 3'd4,
    ST_DST     = 3'd5
  } ihp_status_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_byte;
    logic [16:0] frame_len;
  } ihp_item_t;

  typedef struct packed {
    ihp_status_t status;
    logic [7:0]  traffic_class;
    logic [19:0] flow_id;
    logic [15:0] payload_length;
    logic [7:0]  next_header;
    logic [7:0]  hops_left;
    logic [63:0] src_addr_high;
    logic [63:0] src_addr_low;
    logic [63:0] dst_addr_high;
    logic [63:0] dst_addr_low;
  } ihp_result_t;

endpackage

@@ rtl/ihp_in_stage.sv @@
module ihp_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ihp_pkg::ihp_item_t in_item,
  output logic              item_vld,
  output ihp_pkg::ihp_item_t item,
  input  logic              item_pop
);
  import ihp_pkg::*;

  logic      vld_r, vld_nxt;
  ihp_item_t item_r;
  logic      load;

  // hold the word while the parser cannot take it
  assign in_stall = vld_r && !item_pop;
  assign load     = in_valid && !in_stall;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (item_pop) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

  assign item_vld = vld_r;
  assign item     = item_r;

endmodule

@@ rtl/ihp_parser.sv @@
`include "ipv6_header_parse_check_defines.svh"

module ihp_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                item_vld,
  input  ihp_pkg::ihp_item_t  item,
  input  logic                out_free,
  output logic                item_pop,
  output logic                res_vld,
  output ihp_pkg::ihp_result_t res
);
  import ihp_pkg::*;

  logic [5:0]  pos_r, pos_nxt;
  logic        done_r, done_nxt;
  logic [16:0] len_r, len_nxt;
  logic [63:0] hw_r [HDR_WORDS];

  logic        first;
  logic [16:0] len_eff;
  logic [16:0] len_room;
  logic [5:0]  pos_eff;
  logic        done_eff;
  logic [63:0] new_w4;
  logic [63:0] h0;
  logic        emit;
  logic        upd;
  logic        fin;
  ihp_status_t status;

  always_comb begin
    first    = item.first_byte;
    len_eff  = first ? item.frame_len : len_r;
    pos_eff  = first ? '0 : pos_r;
    done_eff = first ? 1'b0 : done_r;
    len_room = len_eff - HDR_LEN;
    new_w4   = {hw_r[HDR_WORDS-1][55:0], item.data_byte};
    h0       = hw_r[0];
    emit     = 1'b0;
    upd      = 1'b0;
    fin      = 1'b0;
    status   = ST_OK;

    priority if (first && (item.frame_len < HDR_LEN)) begin
      emit   = 1'b1;
      fin    = 1'b1;
      status = ST_SHORT;
    end else if (!done_eff) begin
      priority if (pos_eff >= HDR_POS_END) begin
        fin = 1'b1;
      end else if (pos_eff == POS_VERSION && item.data_byte[7:4] != IP_VERSION) begin
        emit   = 1'b1;
        fin    = 1'b1;
        status = ST_VERSION;
      end else if (pos_eff == POS_PLEN_LO &&
                   len_room < {1'b0, h0[7:0], item.data_byte}) begin
        emit   = 1'b1;
        fin    = 1'b1;
        status = ST_TRUNC;
      end else if (pos_eff == POS_HOP && item.data_byte == '0) begin
        emit   = 1'b1;
        fin    = 1'b1;
        status = ST_HOP;
      end else begin
        upd = 1'b1;
        if (pos_eff == POS_LAST) begin
          emit   = 1'b1;
          fin    = 1'b1;
          status = (hw_r[3] == '0 && new_w4 == '0) ? ST_DST : ST_OK;
        end
      end
    end else begin
      // drop the word while waiting for a first byte
    end

    res        = '0;
    res.status = status;
    if (status == ST_OK) begin
      res.traffic_class  = {h0[59:56], h0[55:52]};
      res.flow_id        = {h0[51:48], h0[47:32]};
      res.payload_length = h0[31:16];
      res.next_header    = h0[15:8];
      res.hops_left      = h0[7:0];
      res.src_addr_high  = hw_r[1];
      res.src_addr_low   = hw_r[2];
      res.dst_addr_high  = hw_r[3];
      res.dst_addr_low   = new_w4;
    end
  end

  // a verdict waits for room in the result register; other bytes never stall
  assign item_pop = item_vld && (!emit || out_free);
  assign res_vld  = item_pop && emit;

  always_comb begin
    len_nxt  = len_r;
    pos_nxt  = pos_r;
    done_nxt = done_r;
    if (item_pop) begin
      len_nxt  = len_eff;
      pos_nxt  = upd ? pos_eff + 6'd1 : pos_eff;
      done_nxt = fin ? 1'b1 : done_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      done_r <= 1'b1;
      len_r  <= '0;
    end else begin
      pos_r  <= pos_nxt;
      done_r <= done_nxt;
      len_r  <= len_nxt;
    end
  end

  // shift the byte into the header word selected by the byte position
  always_ff @(posedge clk) begin
    for (int k = 0; k < HDR_WORDS; k++) begin
      if (item_pop && upd && pos_eff[5:3] == 3'(k)) begin
        hw_r[k] <= {hw_r[k][55:0], item.data_byte};
      end
    end
  end

  `IHP_ASSERT_NOW(a_pos_in_header, !done_r, pos_r < HDR_POS_END, "position past header while parsing")
  `IHP_ASSERT_NEXT(a_verdict_closes, res_vld, done_r, "packet still open after verdict")
  `IHP_ASSERT_NOW(a_err_fields_zero, res_vld && res.status != ST_OK, res.hops_left == '0 && res.dst_addr_low == '0 && res.flow_id == '0, "error verdict carries header fields")

endmodule

@@ rtl/ihp_out_stage.sv @@
module ihp_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 res_vld,
  input  ihp_pkg::ihp_result_t res,
  output logic                 out_free,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ihp_pkg::ihp_result_t out_res
);
  import ihp_pkg::*;

  logic        vld_r, vld_nxt;
  ihp_result_t res_r;

  assign out_free = !vld_r || !out_stall;

  always_comb begin
    vld_nxt = vld_r;
    if (res_vld) begin
      vld_nxt = 1'b1;
    end else if (!out_stall) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_vld) begin
      res_r <= res;
    end
  end

  assign out_valid = vld_r;
  assign out_res   = res_r;

endmodule

@@ rtl/ipv6_header_parse_check.sv @@
// IPv6 fixed-header parser and checker.
// Input channel: one packet byte per word (in_data_byte) in wire order;
// in_first_byte marks the start of a packet and carries in_frame_len, the
// total frame length in bytes. Result channel: at most one verdict word per
// packet, out_status plus the header fields (all zero unless status is ok).
// Verdicts: too short on the first byte, bad version on byte 0, truncated
// payload on byte 5, zero hop limit on byte 7, zero destination or ok on
// byte 39. After a verdict, bytes are dropped until the next first byte; a
// first byte always restarts parsing.
// Path: the byte that causes the verdict passes the input register and the
// parse logic; the output register then holds the verdict for out_valid.
// Throughput: while no verdict byte waits for room, the parse logic between
// the two registers takes one byte each cycle and one byte per cycle enters.
// Stall: while out_stall holds a verdict, a byte that causes no verdict still
// goes through; a byte that would give a verdict waits and in_stall rises.
// Reset (rst_n low, synchronous): both registers empty, the parser waits for
// a first byte.
`include "ipv6_header_parse_check_defines.svh"

module ipv6_header_parse_check (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_first_byte,
  input  logic [16:0] in_frame_len,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [7:0]  out_traffic_class,
  output logic [19:0] out_flow_id,
  output logic [15:0] out_payload_length,
  output logic [7:0]  out_next_header,
  output logic [7:0]  out_hops_left,
  output logic [63:0] out_src_addr_high,
  output logic [63:0] out_src_addr_low,
  output logic [63:0] out_dst_addr_high,
  output logic [63:0] out_dst_addr_low
);
  import ihp_pkg::*;

  ihp_item_t   in_item;
  ihp_item_t   item;
  logic        item_vld;
  logic        item_pop;
  logic        out_free;
  logic        res_vld;
  ihp_result_t res;
  ihp_result_t out_res;

  assign in_item.data_byte  = in_data_byte;
  assign in_item.first_byte = in_first_byte;
  assign in_item.frame_len  = in_frame_len;

  ihp_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .item_vld (item_vld),
    .item     (item),
    .item_pop (item_pop)
  );

  ihp_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .item_vld (item_vld),
    .item     (item),
    .out_free (out_free),
    .item_pop (item_pop),
    .res_vld  (res_vld),
    .res      (res)
  );

  ihp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_vld   (res_vld),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_status         = out_res.status;
  assign out_traffic_class  = out_res.traffic_class;
  assign out_flow_id        = out_res.flow_id;
  assign out_payload_length = out_res.payload_length;
  assign out_next_header    = out_res.next_header;
  assign out_hops_left      = out_res.hops_left;
  assign out_src_addr_high  = out_res.src_addr_high;
  assign out_src_addr_low   = out_res.src_addr_low;
  assign out_dst_addr_high  = out_res.dst_addr_high;
  assign out_dst_addr_low   = out_res.dst_addr_low;

  `IHP_ASSERT_NOW(a_no_overwrite, res_vld, !out_valid || !out_stall, "verdict overwrites a held result")
  `IHP_ASSERT_NOW(a_pop_needs_word, item_pop, item_vld, "parser consumed an empty input register")
  `IHP_ASSERT_NEXT(a_held_result, out_valid && out_stall, out_valid && $stable(out_status), "held result changed")

endmodule
